[rtl/core/assert_macros.svh]
// Assertion macros shared by the column height interpolator RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every rising edge of clk while rst is low
`define CHI_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("chi assertion failed");

// expr must never be true at a rising edge of clk while rst is low
`define CHI_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("chi forbidden condition seen");

`endif

[rtl/core/chi_pkg.sv]
// Package for the column height interpolator: widths, register index,
// controller state type and the command/status structs. No dependencies.
package chi_pkg;

   // field widths
   localparam int GEO_W  = 32;
   localparam int WIND_W = 24;
   localparam int TGT_W  = 28;

   // datapath widths: products, numerator, magnitude, dividend
   localparam int DIFF_W = GEO_W + 2;          // target minus a level, signed
   localparam int PROD_W = 58;                 // wind times DIFF_W, signed
   localparam int MAG_W  = 56;                 // |numerator| plus half divisor
   localparam int DIV_STEPS = WIND_W;          // one quotient bit per step
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_TARGET = 1'b0;     // register index, byte address 0

   // result codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_ABS,
      ST_ROUND,
      ST_DIV
   } chi_state_type;

   typedef struct packed {
      logic load;       // accept a level word
      logic mul;        // form both weighted products
      logic sum;        // add products, form the span
      logic abs;        // take magnitude and sign
      logic round;      // add half span, seed the divider
      logic div_step;   // one restoring division step
      logic emit_ok;    // load the interpolated result
      logic emit_err;   // load the out-of-range result
   } chi_cmd_type;

   typedef struct packed {
      logic found;      // a bracketing pair exists after the current level
   } chi_status_type;

endpackage

[rtl/core/chi_dpath.sv]
// Datapath of the column height interpolator: column state, bracket test,
// products, rounding and the serial divider. Uses chi_pkg.
`include "assert_macros.svh"

module chi_dpath import chi_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  chi_cmd_type              cmd,
   output chi_status_type           dp_status,
   input  logic [TGT_W-1:0]         target,
   input  logic signed [GEO_W-1:0]  level_geo,
   input  logic signed [WIND_W-1:0] level_wind,
   input  logic                     last_level,
   output logic signed [WIND_W-1:0] res_wind,
   output logic                     res_status
);

   // column state
   logic                     first_pending_ff, first_pending_in;
   logic                     bracket_found_ff, bracket_found_in;
   logic signed [GEO_W-1:0]  prev_geo_ff, prev_geo_in;
   logic signed [WIND_W-1:0] prev_wind_ff, prev_wind_in;
   logic signed [GEO_W-1:0]  upper_geo_ff, upper_geo_in;
   logic signed [GEO_W-1:0]  lower_geo_ff, lower_geo_in;
   logic signed [WIND_W-1:0] upper_wind_ff, upper_wind_in;
   logic signed [WIND_W-1:0] lower_wind_ff, lower_wind_in;

   // arithmetic pipeline
   logic signed [PROD_W-1:0] prod_a_ff, prod_a_in;
   logic signed [PROD_W-1:0] prod_b_ff, prod_b_in;
   logic signed [PROD_W-1:0] num_ff, num_in;
   logic [GEO_W-1:0]         span_ff, span_in;
   logic                     neg_ff, neg_in;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic [GEO_W-1:0]         rem_ff, rem_in;
   logic [WIND_W-1:0]        quo_ff, quo_in;
   logic signed [WIND_W-1:0] res_wind_ff, res_wind_in;
   logic                     res_status_ff, res_status_in;

   logic signed [GEO_W:0]    tgt_s, prev_s, geo_s;
   logic                     hit;
   logic signed [DIFF_W-1:0] t_minus_lower, upper_minus_t;
   logic signed [PROD_W-1:0] num_abs;
   logic [MAG_W-1:0]         dividend;
   logic [GEO_W:0]           trial, trial_diff;
   logic                     trial_ge;
   logic [WIND_W-1:0]        quo_next;

   // bracket test: previous level above target, this one at or below
   assign tgt_s  = $signed({{(GEO_W+1-TGT_W){1'b0}}, target});
   assign prev_s = {prev_geo_ff[GEO_W-1], prev_geo_ff};
   assign geo_s  = {level_geo[GEO_W-1], level_geo};
   assign hit    = (tgt_s < prev_s) && (tgt_s >= geo_s);
   assign dp_status.found = !first_pending_ff && (hit || bracket_found_ff);

   // weights of the recorded pair
   assign t_minus_lower = $signed({{(DIFF_W-TGT_W){1'b0}}, target})
                        - $signed({{2{lower_geo_ff[GEO_W-1]}}, lower_geo_ff});
   assign upper_minus_t = $signed({{2{upper_geo_ff[GEO_W-1]}}, upper_geo_ff})
                        - $signed({{(DIFF_W-TGT_W){1'b0}}, target});
   assign num_abs = num_ff[PROD_W-1] ? -num_ff : num_ff;

   // round to nearest: add half the span before truncating division
   assign dividend = mag_ff + {{(MAG_W-GEO_W+1){1'b0}}, span_ff[GEO_W-1:1]};

   // restoring division step, quotient bits shift in at the bottom
   assign trial      = {rem_ff, quo_ff[WIND_W-1]};
   assign trial_diff = trial - {1'b0, span_ff};
   assign trial_ge   = (trial >= {1'b0, span_ff});
   assign quo_next   = {quo_ff[WIND_W-2:0], trial_ge};

   // column state update on each accepted level
   always_comb begin
      first_pending_in = first_pending_ff;
      bracket_found_in = bracket_found_ff;
      prev_geo_in      = prev_geo_ff;
      prev_wind_in     = prev_wind_ff;
      upper_geo_in     = upper_geo_ff;
      lower_geo_in     = lower_geo_ff;
      upper_wind_in    = upper_wind_ff;
      lower_wind_in    = lower_wind_ff;
      if (cmd.load) begin
         if (first_pending_ff) begin
            bracket_found_in = 1'b0;
            first_pending_in = 1'b0;
         end else if (hit) begin
            bracket_found_in = 1'b1;
            upper_geo_in     = prev_geo_ff;
            lower_geo_in     = level_geo;
            upper_wind_in    = prev_wind_ff;
            lower_wind_in    = level_wind;
         end
         prev_geo_in  = level_geo;
         prev_wind_in = level_wind;
         if (last_level) begin
            first_pending_in = 1'b1;
         end
      end
   end

   // interpolation sequence
   always_comb begin
      prod_a_in     = prod_a_ff;
      prod_b_in     = prod_b_ff;
      num_in        = num_ff;
      span_in       = span_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      res_wind_in   = res_wind_ff;
      res_status_in = res_status_ff;
      if (cmd.mul) begin
         prod_a_in = upper_wind_ff * t_minus_lower;
         prod_b_in = lower_wind_ff * upper_minus_t;
      end
      if (cmd.sum) begin
         num_in  = prod_a_ff + prod_b_ff;
         span_in = upper_geo_ff - lower_geo_ff;
      end
      if (cmd.abs) begin
         neg_in = num_ff[PROD_W-1];
         mag_in = num_abs[MAG_W-1:0];
      end
      if (cmd.round) begin
         rem_in = dividend[MAG_W-1:WIND_W];
         quo_in = dividend[WIND_W-1:0];
      end
      if (cmd.div_step) begin
         rem_in = trial_ge ? trial_diff[GEO_W-1:0] : trial[GEO_W-1:0];
         quo_in = quo_next;
      end
      if (cmd.emit_ok) begin
         res_wind_in   = neg_ff ? -$signed(quo_next) : $signed(quo_next);
         res_status_in = STATUS_OK;
      end
      if (cmd.emit_err) begin
         res_wind_in   = '0;
         res_status_in = STATUS_RANGE;
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         first_pending_ff <= 1'b1;
         bracket_found_ff <= 1'b0;
      end else begin
         first_pending_ff <= first_pending_in;
         bracket_found_ff <= bracket_found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prev_geo_ff   <= prev_geo_in;
      prev_wind_ff  <= prev_wind_in;
      upper_geo_ff  <= upper_geo_in;
      lower_geo_ff  <= lower_geo_in;
      upper_wind_ff <= upper_wind_in;
      lower_wind_ff <= lower_wind_in;
      prod_a_ff     <= prod_a_in;
      prod_b_ff     <= prod_b_in;
      num_ff        <= num_in;
      span_ff       <= span_in;
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      res_wind_ff   <= res_wind_in;
      res_status_ff <= res_status_in;
   end

   assign res_wind   = res_wind_ff;
   assign res_status = res_status_ff;

   // a closing level always re-arms the column start
   `CHI_ASSERT(a_last_rearms, clock, reset, cmd.load && last_level |=> first_pending_ff)
   // a found pair never comes from an empty span
   `CHI_NEVER(a_span_nonzero, clock, reset, cmd.round && (span_ff == '0))

endmodule

[rtl/core/chi_ctrl.sv]
// Controller of the column height interpolator: handshakes, the state
// machine that sequences the datapath, and the result valid flag. Uses chi_pkg.
`include "assert_macros.svh"

module chi_ctrl import chi_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  logic           req_tlast,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  chi_status_type dp_status,
   output chi_cmd_type    cmd
);

   chi_state_type        state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 slot_free;
   logic                 req_fire;

   // the result register is free if empty or being read this cycle
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   // a closing level also needs the result register; any level waits while a column is computed
   assign req_tready = (state_ff == ST_IDLE) && (!req_tlast || slot_free);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               if (req_tlast) begin
                  if (dp_status.found) begin
                     state_in = ST_MUL;
                  end else begin
                     cmd.emit_err = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            cmd.abs  = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round  = 1'b1;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               cmd.emit_ok  = 1'b1;
               rsp_valid_in = 1'b1;
               div_cnt_in   = '0;
               state_in     = ST_IDLE;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in   = ST_IDLE;
            div_cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // the result register stays empty while a column is being computed
   `CHI_ASSERT(a_slot_empty_busy, clock, reset, state_ff != ST_IDLE |-> !rsp_valid_ff)
   // the step counter only runs inside the division
   `CHI_ASSERT(a_cnt_div_only, clock, reset, state_ff != ST_DIV |-> div_cnt_ff == '0)
   // a column without a bracketing pair answers on the next cycle
   `CHI_ASSERT(a_err_next, clock, reset, req_fire && req_tlast && !dp_status.found |=> rsp_valid_ff)

endmodule

[rtl/core/column_height_interpolator_top.sv]
// Column height interpolator: levels of a column stream in top first; the
// bottom level (req_tlast) produces one interpolated wind word on rsp_*.
// Channels: req_tdata = {level_wind, level_geopotential}, 56 bits, tlast =
// last_level. rsp_tdata = wind_at_height (24 bits), rsp_tuser = status.
// Config: csr_* register target_geopotential at byte address 0.
// Throughput: a level that is not the last is taken every cycle while no
// column is being computed. A bottom level with no bracketing pair answers in
// the next cycle. One that has a pair is answered after the multiply, add,
// magnitude and rounding steps and the restoring divider, one quotient bit per
// cycle; no level is taken during that time.
// The result sits in an output register; while it waits, levels that do not
// close a column are still taken, and a bottom level waits until the result
// register is free.
// Reset clears the target to zero, drops rsp_tvalid and starts a new column.
// Depends on chi_pkg, chi_ctrl and chi_dpath.

module column_height_interpolator_top import chi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // stream in
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [55:0]           req_tdata,   // [31:0] level_geopotential, [55:32] level_wind
   input  logic                  req_tlast,   // last_level
   // stream out
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [WIND_W-1:0]     rsp_tdata,   // [23:0] wind_at_height
   output logic                  rsp_tuser,   // [0] status
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [TGT_W-1:0]         target_ff, target_in;
   logic                     csr_write;
   logic                     csr_idx;
   chi_cmd_type              cmd;
   chi_status_type           dp_status;
   logic signed [WIND_W-1:0] res_wind;
   logic                     res_status;

   // register decode: word index is address bit 2
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      target_in  = target_ff;
      csr_prdata = '0;
      unique case (csr_idx)
         CSR_IDX_TARGET: begin
            csr_prdata = {{(CSR_DATA_W-TGT_W){1'b0}}, target_ff};
            if (csr_write) begin
               target_in = csr_pwdata[TGT_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else begin
         target_ff <= target_in;
      end
   end

   chi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   chi_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .dp_status  (dp_status),
      .target     (target_ff),
      .level_geo  ($signed(req_tdata[GEO_W-1:0])),
      .level_wind ($signed(req_tdata[GEO_W+WIND_W-1:GEO_W])),
      .last_level (req_tlast),
      .res_wind   (res_wind),
      .res_status (res_status)
   );

   assign rsp_tdata = res_wind;
   assign rsp_tuser = res_status;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for column_height_interpolator_top: streams directed and random
// columns of levels, predicts each bottom-level word and checks it field by field.
// Depends on chi_pkg and the RTL of the interpolator.
module tb_top import chi_pkg::*; ();

   localparam logic [CSR_ADDR_W-1:0] TARGET_ADDR = CSR_ADDR_W'(4 * int'(CSR_IDX_TARGET));
   localparam longint GEO_HI = 64'sd2147483647;
   localparam longint GEO_LO = -64'sd2147483648;

   typedef struct {
      logic [WIND_W-1:0] wind;
      logic              status;
   } wind_result_type;

   // Predicts the interpolated wind per column and holds the words still due.
   class wind_scoreboard;
      logic [TGT_W-1:0]         target;
      bit                       col_start;
      bit                       have_pair;
      logic signed [GEO_W-1:0]  prev_geo, up_geo, lo_geo;
      logic signed [WIND_W-1:0] prev_wind, up_wind, lo_wind;
      wind_result_type          expected_words[$];
      int unsigned              errors, levels, columns, ok_words, range_words;

      function new();
         target    = '0;
         col_start = 1'b1;
         have_pair = 1'b0;
         prev_geo  = '0;
         up_geo    = '0;
         lo_geo    = '0;
         prev_wind = '0;
         up_wind   = '0;
         lo_wind   = '0;
      endfunction

      function void set_target(logic [CSR_DATA_W-1:0] value);
         target = value[TGT_W-1:0];
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10) $display("mismatch at %0t ns: %s", $time, msg);
      endfunction

      // one accepted level; a bottom level queues its expected word
      function void note_level(logic signed [GEO_W-1:0] geo, logic signed [WIND_W-1:0] wind,
                               bit last);
         longint          tgt, span, num, rounded;
         longint unsigned mag, uspan, q;
         wind_result_type word;
         tgt = target;
         levels++;
         if (col_start) begin
            have_pair = 1'b0;
            col_start = 1'b0;
         end else if (tgt < prev_geo && tgt >= geo) begin
            have_pair = 1'b1;
            up_geo    = prev_geo;
            lo_geo    = geo;
            up_wind   = prev_wind;
            lo_wind   = wind;
         end
         prev_geo  = geo;
         prev_wind = wind;
         if (!last) return;
         col_start = 1'b1;
         columns++;
         if (have_pair) begin
            span  = longint'(up_geo) - longint'(lo_geo);
            num   = up_wind * (tgt - longint'(lo_geo)) + lo_wind * (longint'(up_geo) - tgt);
            uspan = span;
            if (num < 0) mag = -num;
            else mag = num;
            // round half away from zero on the magnitude
            q       = (mag + uspan / 2) / uspan;
            rounded = (num < 0) ? -longint'(q) : longint'(q);
            word.wind   = rounded[WIND_W-1:0];
            word.status = STATUS_OK;
            ok_words++;
         end else begin
            word.wind   = '0;
            word.status = STATUS_RANGE;
            range_words++;
         end
         expected_words.push_back(word);
      endfunction

      function void check_result(logic [WIND_W-1:0] wind, logic status);
         wind_result_type word;
         if (expected_words.size() == 0) begin
            report($sformatf("word with nothing due: wind %h status %b", wind, status));
            return;
         end
         word = expected_words.pop_front();
         if (wind !== word.wind)
            report($sformatf("wind expected %h got %h", word.wind, wind));
         if (status !== word.status)
            report($sformatf("status expected %b got %b", word.status, status));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [55:0]           req_tdata;   // [31:0] level_geopotential, [55:32] level_wind
   logic                  req_tlast;   // last_level
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [WIND_W-1:0]     rsp_tdata;   // [23:0] wind_at_height
   logic                  rsp_tuser;   // [0] status
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   wind_scoreboard sb;
   bit             no_idle;
   int unsigned    settings;

   column_height_interpolator_top u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // setup then access cycle; predictor follows at the write edge
   task automatic write_target(input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TARGET_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_target(value);
      settings++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // one level word; tvalid stays high when the next word follows at once
   task automatic send_level(input logic signed [GEO_W-1:0] geo,
                             input logic signed [WIND_W-1:0] wind, input bit last);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {wind, geo};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_level(geo, wind, last);
   endtask

   // stop sending, let every due word arrive, then cover the divider latency
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // result side: random stall before each word, none in no-idle phases
   initial begin : rsp_side
      int unsigned stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   initial begin : stimulus
      int unsigned              n, kind, phase;
      longint                   tgt, geo, scale;
      logic [CSR_DATA_W-1:0]    value;
      logic signed [WIND_W-1:0] wind;
      sb = new();
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset target is zero; a lone bottom level forms no pair
      send_level(32'sd5, 24'sd7, 1'b1);
      // widest winds over a small span
      send_level(32'sd256, 24'sh7F_FFFF, 1'b0);
      send_level(-32'sd256, 24'sh80_0000, 1'b1);
      // target equal to the lower level brackets, equal to the upper does not
      send_level(32'sd10, 24'sd100, 1'b0);
      send_level(32'sd0, 24'sd200, 1'b1);
      send_level(32'sd0, 24'sd100, 1'b0);
      send_level(-32'sd10, 24'sd200, 1'b1);
      drain();
      write_target(32'd200840192);
      // full geopotential span
      send_level(32'sh7FFF_FFFF, 24'sh80_0000, 1'b0);
      send_level(32'sh8000_0000, 24'sh7F_FFFF, 1'b1);
      // non-monotonic column, lowest bracketing pair wins
      send_level(32'sd200841192, 24'sd1, 1'b0);
      send_level(32'sd200839192, 24'sd2, 1'b0);
      send_level(32'sd200840692, 24'sd3, 1'b0);
      send_level(32'sd200839692, 24'sd4, 1'b1);
      // exact halves round away from zero, both signs
      send_level(32'sd200840193, 24'sd1, 1'b0);
      send_level(32'sd200840191, 24'sd0, 1'b1);
      send_level(32'sd200840193, -24'sd1, 1'b0);
      send_level(32'sd200840191, 24'sd0, 1'b1);
      // whole column below the target
      send_level(32'sd0, 24'sd9, 1'b0);
      send_level(-32'sd1, 24'sd8, 1'b0);
      send_level(-32'sd2, 24'sd7, 1'b1);
      drain();
      // target above the stated range, upper write bits dropped
      write_target(32'hFFFF_FFFF);
      send_level(32'sd268435556, 24'sd50, 1'b0);
      send_level(32'sd268435400, 24'sd70, 1'b1);
      // target changed mid-column: new value used, earlier pair kept
      send_level(32'sd3000, 24'sd5, 1'b0);
      drain();
      write_target(32'd1000);
      send_level(32'sd500, 24'sd60, 1'b0);
      drain();
      write_target(32'd800);
      send_level(-32'sd100, 24'sd30, 1'b1);
      drain();

      // random phases, one target setting each
      phase = 0;
      while (sb.levels < 1375) begin
         case (phase)
            0:       value = 32'd0;
            1:       value = 32'd200840192;
            2:       value = 32'h0FFF_FFFF;
            default: value = ($urandom_range(0, 3) == 0) ? $urandom
                                                          : $urandom_range(0, 200840192);
         endcase
         write_target(value);
         tgt     = value[TGT_W-1:0];
         no_idle = (phase % 3 == 2);
         repeat (25) begin
            n     = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 137)
                                                 : $urandom_range(1, 10);
            kind  = $urandom_range(0, 99);
            scale = longint'(1) << $urandom_range(0, 26);
            // well-formed columns start above the target and step down across it
            if (kind >= 85) geo = tgt - (longint'(n) * scale) / 2;
            else geo = tgt + (longint'(n) * scale) / 2
                       + longint'($urandom_range(0, 32'(scale - 1)));
            for (int i = 0; i < n; i++) begin
               if (kind < 15) begin
                  // noise levels anywhere in the field
                  case ($urandom_range(0, 9))
                     0:       geo = longint'(32'sh7FFF_FFFF);
                     1:       geo = longint'(32'sh8000_0000);
                     default: geo = longint'($signed($urandom));
                  endcase
               end else if (kind < 85) begin
                  if (i > 0) geo = geo - longint'($urandom_range(1, 32'(scale)));
                  if ($urandom_range(0, 7) == 0) geo = tgt;
               end else begin
                  // broken column: rising instead of falling
                  if (i > 0) geo = geo + longint'($urandom_range(1, 32'(scale)));
               end
               if (geo > GEO_HI) geo = GEO_HI;
               if (geo < GEO_LO) geo = GEO_LO;
               wind = WIND_W'($urandom);
               if ($urandom_range(0, 15) == 0)
                  wind = $urandom_range(0, 1) ? 24'sh7F_FFFF : 24'sh80_0000;
               send_level(geo[GEO_W-1:0], wind, i == n - 1);
            end
         end
         drain();
         phase++;
      end

      $display("covered %0d levels in %0d columns over %0d target settings",
               sb.levels, sb.columns, settings);
      $display("words: %0d interpolated, %0d out of range, %0d mismatches",
               sb.ok_words, sb.range_words, sb.errors);
      if (sb.errors == 0 && sb.expected_words.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // run limit
   initial begin : watchdog
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/chi_pkg.sv
rtl/core/chi_dpath.sv
rtl/core/chi_ctrl.sv
rtl/core/column_height_interpolator_top.sv
tb/tb_top.sv
